// ===== sv/wsps_pkg.sv =====
`default_nettype none

package wsps_pkg;

  localparam int PID_W      = 8;
  localparam int SLOT_COUNT = 19;
  localparam int SLOT_W     = 5;
  localparam int NUM_QUEUES = 3;

  localparam logic [1:0] Q_LOW  = 2'd0;
  localparam logic [1:0] Q_MID  = 2'd1;
  localparam logic [1:0] Q_HIGH = 2'd2;
  localparam logic [1:0] Q_NONE = 2'd3;

  localparam logic [1:0] CMD_ENQ = 2'd0;
  localparam logic [1:0] CMD_CHG = 2'd1;
  localparam logic [1:0] CMD_SEL = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic [1:0] SLOT_QUEUE [SLOT_COUNT] = '{
    Q_HIGH, Q_MID, Q_LOW, Q_HIGH, Q_MID, Q_LOW, Q_HIGH, Q_MID, Q_LOW, Q_HIGH,
    Q_MID, Q_LOW, Q_MID, Q_LOW, Q_MID, Q_LOW, Q_LOW, Q_LOW, Q_LOW
  };

  typedef struct packed {
    logic             shift_all;
    logic             shift_hit;
    logic             load;
    logic [PID_W-1:0] pid;
  } cell_ctl_t;

  function automatic logic [1:0] prio_to_queue(input logic [1:0] prio);
    logic [1:0] q;
    unique case (prio)
      2'b11:   q = Q_LOW;
      2'b00:   q = Q_MID;
      2'b01:   q = Q_HIGH;
      default: q = Q_NONE;
    endcase
    return q;
  endfunction

endpackage

`default_nettype wire

// ===== sv/wsps_if.sv =====
`default_nettype none

interface wsps_cmd_if import wsps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [PID_W-1:0]  pid;
  logic signed [1:0] priority_req;

  modport source (output valid, command, pid, priority_req, input ready);
  modport sink   (input valid, command, pid, priority_req, output ready);
endinterface

interface wsps_res_if import wsps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             granted;
  logic [PID_W-1:0] run_pid;
  logic             ran_idle;
  logic [1:0]       status;

  modport source (output valid, granted, run_pid, ran_idle, status, input ready);
  modport sink   (input valid, granted, run_pid, ran_idle, status, output ready);
endinterface

`default_nettype wire

// ===== sv/weighted_slot_priority_scheduler_core.sv =====
// channel | dir | handshake     | word
// cmd     | in  | valid / ready | command, pid, priority_req
// res     | out | valid / ready | granted, run_pid, ran_idle, status
//
// one command at a time; enqueue and unused codes answer in the cycle after they are taken
// select walks the slot table one slot a cycle until a slot's queue is not empty, or answers idle if all are empty
// priority change runs the match flag down the cell row of all three queues, then decides
// rst is synchronous and empties all queues and sets the slot position to 0
// cmd stalls while a word waits in the result register or a command is in work
`default_nettype none

module weighted_slot_priority_scheduler_core import wsps_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  wsps_cmd_if.sink      cmd,
  wsps_res_if.source    res
);

  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int SCAN_LEN = NUM_QUEUES * QUEUE_DEPTH;
  localparam int SCAN_W   = $clog2(SCAN_LEN);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_WALK   = 2'd3;

  logic [1:0]        state, state_next;
  logic [SCAN_W-1:0] scan_cnt, scan_cnt_next;
  logic [PID_W-1:0]  cur_pid, cur_pid_next;
  logic [1:0]        cur_q, cur_q_next;
  logic [SLOT_W-1:0] slot_pos, slot_pos_next;

  logic              res_valid;
  logic              res_granted;
  logic [PID_W-1:0]  res_run_pid;
  logic              res_ran_idle;
  logic [1:0]        res_status;

  logic              wr;
  logic              wr_granted;
  logic [PID_W-1:0]  wr_run_pid;
  logic              wr_ran_idle;
  logic [1:0]        wr_status;

  cell_ctl_t         qctl [NUM_QUEUES];
  logic              q_seen [NUM_QUEUES+1];
  logic [CNT_W-1:0]  fill [NUM_QUEUES];
  logic [PID_W-1:0]  head [NUM_QUEUES];
  logic [3:0]        full_v;
  logic [NUM_QUEUES-1:0] empty_v;

  logic              accept;
  logic [1:0]        tq;
  logic [1:0]        fq;
  logic [1:0]        sq;
  logic [SLOT_W-1:0] slot_inc;

  assign q_seen[0] = 1'b0;

  for (genvar q = 0; q < NUM_QUEUES; q++) begin : g_queue
    wsps_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .CNT_W       (CNT_W)
    ) u_queue (
      .clk      (clk),
      .rst      (rst),
      .ctl      (qctl[q]),
      .seen_in  (q_seen[q]),
      .seen_out (q_seen[q+1]),
      .fill     (fill[q]),
      .head     (head[q])
    );
    assign full_v[q]  = (fill[q] == CNT_W'(QUEUE_DEPTH));
    assign empty_v[q] = (fill[q] == '0);
  end
  assign full_v[3] = 1'b1;

  assign cmd.ready = (state == S_IDLE) && (!res_valid || res.ready);
  assign accept    = cmd.valid && cmd.ready;
  assign tq        = prio_to_queue(cmd.priority_req);
  assign sq        = SLOT_QUEUE[slot_pos];
  assign slot_inc  = (slot_pos == SLOT_W'(SLOT_COUNT - 1)) ? '0 : slot_pos + 1'b1;

  always_comb begin
    priority if (q_seen[1]) begin
      fq = Q_LOW;
    end else if (q_seen[2]) begin
      fq = Q_MID;
    end else begin
      fq = Q_HIGH;
    end
  end

  always_comb begin
    state_next    = state;
    scan_cnt_next = scan_cnt;
    cur_pid_next  = cur_pid;
    cur_q_next    = cur_q;
    slot_pos_next = slot_pos;
    wr            = 1'b0;
    wr_granted    = 1'b0;
    wr_run_pid    = '0;
    wr_ran_idle   = 1'b0;
    wr_status     = STATUS_OK;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      qctl[q].shift_all = 1'b0;
      qctl[q].shift_hit = 1'b0;
      qctl[q].load      = 1'b0;
      qctl[q].pid       = cur_pid;
    end

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd.command)
            CMD_ENQ: begin
              wr = 1'b1;
              if (full_v[tq]) begin
                wr_status = STATUS_FULL;
              end else begin
                for (int q = 0; q < NUM_QUEUES; q++) begin
                  if (2'(q) == tq) begin
                    qctl[q].load = 1'b1;
                    qctl[q].pid  = cmd.pid;
                  end
                end
              end
            end
            CMD_CHG: begin
              if (tq == Q_NONE) begin
                wr        = 1'b1;
                wr_status = STATUS_FULL;
              end else begin
                cur_pid_next  = cmd.pid;
                cur_q_next    = tq;
                scan_cnt_next = SCAN_W'(SCAN_LEN - 1);
                state_next    = S_SCAN;
              end
            end
            CMD_SEL: begin
              state_next = S_WALK;
            end
            default: begin
              wr = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_cnt == '0) begin
          state_next = S_DECIDE;
        end else begin
          scan_cnt_next = scan_cnt - 1'b1;
        end
      end
      S_DECIDE: begin
        wr         = 1'b1;
        state_next = S_IDLE;
        priority if (!q_seen[NUM_QUEUES]) begin
          wr_status = STATUS_NOT_FOUND;
        end else if (fq != cur_q && full_v[cur_q]) begin
          wr_status = STATUS_FULL;
        end else begin
          for (int q = 0; q < NUM_QUEUES; q++) begin
            qctl[q].shift_hit = (2'(q) == fq);
            qctl[q].load      = (2'(q) == cur_q);
          end
        end
      end
      S_WALK: begin
        slot_pos_next = slot_inc;
        priority if (&empty_v) begin
          wr          = 1'b1;
          wr_ran_idle = 1'b1;
          state_next  = S_IDLE;
        end else if (fill[sq] != '0) begin
          wr         = 1'b1;
          wr_granted = 1'b1;
          wr_run_pid = head[sq];
          state_next = S_IDLE;
          for (int q = 0; q < NUM_QUEUES; q++) begin
            qctl[q].shift_all = (2'(q) == sq);
          end
        end else begin
          state_next = S_WALK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      slot_pos  <= '0;
      res_valid <= 1'b0;
    end else begin
      state    <= state_next;
      slot_pos <= slot_pos_next;
      if (wr) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_cnt <= scan_cnt_next;
    cur_pid  <= cur_pid_next;
    cur_q    <= cur_q_next;
    if (wr) begin
      res_granted  <= wr_granted;
      res_run_pid  <= wr_run_pid;
      res_ran_idle <= wr_ran_idle;
      res_status   <= wr_status;
    end
  end

  assign res.valid    = res_valid;
  assign res.granted  = res_granted;
  assign res.run_pid  = res_run_pid;
  assign res.ran_idle = res_ran_idle;
  assign res.status   = res_status;

endmodule

`default_nettype wire

// ===== sv/wsps_cell.sv =====
`default_nettype none

module wsps_cell import wsps_pkg::*; (
  input  wire logic             clk,
  input  wire cell_ctl_t        ctl,
  input  wire logic             valid,
  input  wire logic             load_here,
  input  wire logic [PID_W-1:0] next_val,
  input  wire logic             seen_in,
  output logic                  seen_out,
  output logic [PID_W-1:0]      value
);

  logic seen;
  logic match;
  logic shift;
  logic [PID_W-1:0] value_next;

  assign match    = valid && (value == ctl.pid);
  assign seen_out = seen | match;
  assign shift    = ctl.shift_all | (ctl.shift_hit & seen_out);

  always_comb begin
    priority if (ctl.load && load_here) begin
      value_next = ctl.pid;
    end else if (shift) begin
      value_next = next_val;
    end else begin
      value_next = value;
    end
  end

  always_ff @(posedge clk) begin
    seen  <= seen_in;
    value <= value_next;
  end

endmodule

`default_nettype wire

// ===== sv/wsps_queue.sv =====
`default_nettype none

module wsps_queue import wsps_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cell_ctl_t        ctl,
  input  wire logic             seen_in,
  output logic                  seen_out,
  output logic [CNT_W-1:0]      fill,
  output logic [PID_W-1:0]      head
);

  logic [PID_W-1:0] vals [QUEUE_DEPTH];
  logic             seen [QUEUE_DEPTH+1];
  logic [CNT_W-1:0] fill_next;
  logic [CNT_W-1:0] load_idx;
  logic             dec;

  assign dec       = ctl.shift_all | ctl.shift_hit;
  assign load_idx  = fill - CNT_W'(dec);
  assign fill_next = load_idx + CNT_W'(ctl.load);
  assign seen[0]   = seen_in;
  assign seen_out  = seen[QUEUE_DEPTH];
  assign head      = vals[0];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [PID_W-1:0] next_val;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_val = '0;
    end else begin : g_mid
      assign next_val = vals[i+1];
    end
    wsps_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .valid     (CNT_W'(i) < fill),
      .load_here (CNT_W'(i) == load_idx),
      .next_val  (next_val),
      .seen_in   (seen[i]),
      .seen_out  (seen[i+1]),
      .value     (vals[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

endmodule

`default_nettype wire

// ===== verif/wsps_sched_checker.sv =====
`timescale 1ns / 100ps

module wsps_sched_checker import wsps_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  wsps_cmd_if       cmd,
  wsps_res_if       res,
  output int        fail_count,
  output int        words_pending
);

  typedef struct packed {
    logic             granted;
    logic [PID_W-1:0] run_pid;
    logic             ran_idle;
    logic [1:0]       status;
  } sched_word_t;

  logic [PID_W-1:0] ready_pids [NUM_QUEUES][QUEUE_DEPTH];
  int               fill [NUM_QUEUES];
  int               slot_pos;
  sched_word_t      expected_words [$];

  int n_words   = 0;
  int n_grant   = 0;
  int n_idle    = 0;
  int n_full    = 0;
  int n_missing = 0;

  function automatic logic [1:0] target_queue(logic [1:0] pr);
    int v;
    v = $signed(pr);
    if (v == -1) return Q_LOW;
    else if (v == 0) return Q_MID;
    else if (v == 1) return Q_HIGH;
    else return Q_NONE;
  endfunction

  function automatic void push_pid(int q, logic [PID_W-1:0] p);
    ready_pids[q][fill[q]] = p;
    fill[q]++;
  endfunction

  function automatic void pop_at(int q, int idx);
    for (int i = idx; i + 1 < fill[q]; i++) ready_pids[q][i] = ready_pids[q][i + 1];
    fill[q]--;
  endfunction

  function automatic sched_word_t predict_word(logic [1:0] c, logic [PID_W-1:0] p,
                                               logic [1:0] pr);
    sched_word_t w;
    logic [1:0]  tq;
    int          fq;
    int          fi;
    int          q;
    w  = '0;
    tq = target_queue(pr);
    fq = -1;
    fi = 0;
    case (c)
      CMD_ENQ: begin
        if (tq == Q_NONE || fill[tq] >= QUEUE_DEPTH) w.status = STATUS_FULL;
        else push_pid(int'(tq), p);
      end
      CMD_CHG: begin
        // first match wins: low queue, then mid, then high, head to tail
        for (q = 0; q < NUM_QUEUES; q++) begin
          for (int i = 0; i < fill[q]; i++) begin
            if (fq < 0 && ready_pids[q][i] == p) begin
              fq = q;
              fi = i;
            end
          end
        end
        if (tq == Q_NONE) w.status = STATUS_FULL;
        else if (fq < 0) w.status = STATUS_NOT_FOUND;
        else if (fq != int'(tq) && fill[tq] >= QUEUE_DEPTH) w.status = STATUS_FULL;
        else begin
          pop_at(fq, fi);
          push_pid(int'(tq), p);
        end
      end
      CMD_SEL: begin
        if (fill[0] == 0 && fill[1] == 0 && fill[2] == 0) begin
          w.ran_idle = 1'b1;
          slot_pos   = (slot_pos + 1) % SLOT_COUNT;
        end else begin
          for (int n = 0; n < SLOT_COUNT && !w.granted; n++) begin
            q = int'(SLOT_QUEUE[slot_pos]);
            if (fill[q] > 0) begin
              w.granted = 1'b1;
              w.run_pid = ready_pids[q][0];
              pop_at(q, 0);
            end
            slot_pos = (slot_pos + 1) % SLOT_COUNT;
          end
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  always @(posedge clk) begin
    sched_word_t exp_w;
    sched_word_t got_w;
    if (rst) begin
      for (int q = 0; q < NUM_QUEUES; q++) fill[q] = 0;
      slot_pos   = 0;
      fail_count = 0;
      expected_words.delete();
    end else begin
      if (cmd.valid && cmd.ready)
        expected_words.push_back(predict_word(cmd.command, cmd.pid, cmd.priority_req));
      if (res.valid && res.ready) begin
        got_w = {res.granted, res.run_pid, res.ran_idle, res.status};
        n_words++;
        if (expected_words.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result word with nothing expected: granted %0b pid %02h idle %0b st %0d",
                     $realtime, got_w.granted, got_w.run_pid, got_w.ran_idle, got_w.status);
          fail_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (got_w.granted !== exp_w.granted || got_w.run_pid !== exp_w.run_pid ||
              got_w.ran_idle !== exp_w.ran_idle || got_w.status !== exp_w.status) begin
            if (fail_count < 10)
              $display("%0t: mismatch exp granted %0b pid %02h idle %0b st %0d, got %0b %02h %0b %0d",
                       $realtime, exp_w.granted, exp_w.run_pid, exp_w.ran_idle, exp_w.status,
                       got_w.granted, got_w.run_pid, got_w.ran_idle, got_w.status);
            fail_count++;
          end
          if (exp_w.granted) n_grant++;
          if (exp_w.ran_idle) n_idle++;
          if (exp_w.status == STATUS_FULL) n_full++;
          if (exp_w.status == STATUS_NOT_FOUND) n_missing++;
        end
      end
    end
    words_pending = expected_words.size();
  end

  task print_summary();
    $display("checked %0d result words: %0d grants, %0d idle selects", n_words, n_grant, n_idle);
    $display("rejects seen: %0d full or unnamed queue, %0d unknown pid", n_full, n_missing);
  endtask

endmodule

// ===== verif/weighted_slot_priority_scheduler_core_test.sv =====
`timescale 1ns / 100ps

module weighted_slot_priority_scheduler_core_test;
  import wsps_pkg::*;

  localparam int         QUEUE_DEPTH  = 16;
  localparam int         CYCLE_LIMIT  = 1_000_000;
  localparam int         DRAIN_CYCLES = 64;
  localparam int         PHASE_LEN    = 100;
  localparam int         PHASES       = 17;
  localparam logic [1:0] CMD_NOP      = 2'd3;

  typedef enum int {PH_FILL, PH_MIX, PH_DRAIN} phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   words_pending;
  int   cycle_count = 0;
  int   rx_hold = 0;
  logic tx_burst = 1'b0;
  logic rx_burst = 1'b0;
  logic [PID_W-1:0] pid_history [$];

  wsps_cmd_if cmd_ch ();
  wsps_res_if res_ch ();

  weighted_slot_priority_scheduler_core #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  wsps_sched_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) chk (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd_ch),
    .res           (res_ch),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count, words_pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side stall, drawn once per accepted word
  always @(posedge clk) begin
    int hold;
    if (rst) begin
      res_ch.ready <= 1'b0;
      rx_hold      <= 0;
    end else if (res_ch.valid && res_ch.ready) begin
      hold = rx_burst ? 0 : $urandom_range(0, 11);
      rx_hold      <= hold;
      res_ch.ready <= (hold == 0);
    end else if (rx_hold > 0) begin
      rx_hold      <= rx_hold - 1;
      res_ch.ready <= (rx_hold == 1);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  task automatic send_word(logic [1:0] c, logic [PID_W-1:0] p, int prio);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.command      <= c;
    cmd_ch.pid          <= p;
    cmd_ch.priority_req <= prio[1:0];
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  function automatic int pick_priority();
    if ($urandom_range(0, 99) < 6) return -2;
    return int'($urandom_range(0, 2)) - 1;
  endfunction

  task automatic send_random(phase_t ph);
    int               roll;
    int               enq_w;
    int               chg_w;
    logic [PID_W-1:0] p;
    roll  = $urandom_range(0, 99);
    enq_w = (ph == PH_FILL) ? 55 : (ph == PH_MIX) ? 35 : 18;
    chg_w = (ph == PH_FILL) ? 25 : (ph == PH_MIX) ? 25 : 20;
    p     = ($urandom_range(0, 1) == 0) ? PID_W'($urandom_range(0, 15))
                                        : PID_W'($urandom_range(0, 255));
    if (roll < enq_w) begin
      pid_history.push_back(p);
      if (pid_history.size() > 64) void'(pid_history.pop_front());
      send_word(CMD_ENQ, p, pick_priority());
    end else if (roll < enq_w + chg_w) begin
      if (pid_history.size() > 0 && $urandom_range(0, 3) != 0)
        p = pid_history[$urandom_range(0, pid_history.size() - 1)];
      send_word(CMD_CHG, p, pick_priority());
    end else if (roll < 96) begin
      send_word(CMD_SEL, p, pick_priority());
    end else begin
      send_word(CMD_NOP, p, pick_priority());
    end
  endtask

  initial begin
    phase_t ph;
    cmd_ch.valid        = 1'b0;
    cmd_ch.command      = CMD_ENQ;
    cmd_ch.pid          = '0;
    cmd_ch.priority_req = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(CMD_SEL, 8'hFF, -2);
    send_word(CMD_ENQ, 8'h00, -1);
    send_word(CMD_ENQ, 8'hFF, 1);
    send_word(CMD_ENQ, 8'hA5, 0);
    send_word(CMD_ENQ, 8'h5A, 0);
    send_word(CMD_ENQ, 8'h11, -2);
    send_word(CMD_CHG, 8'h77, 0);
    send_word(CMD_CHG, 8'hFF, -2);
    send_word(CMD_CHG, 8'hA5, 0);
    send_word(CMD_CHG, 8'h00, 1);
    send_word(CMD_ENQ, 8'h5A, -1);
    send_word(CMD_CHG, 8'h5A, 1);
    send_word(CMD_NOP, 8'hFF, -2);
    repeat (9) send_word(CMD_SEL, 8'h00, 0);

    for (int k = 0; k < PHASES; k++) begin
      ph       = phase_t'($urandom_range(0, 2));
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      repeat (PHASE_LEN) send_random(ph);
    end
    cmd_ch.valid <= 1'b0;

    do @(posedge clk); while (words_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    chk.print_summary();
    if (fail_count == 0 && words_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/wsps_pkg.sv
sv/wsps_if.sv
sv/wsps_cell.sv
sv/wsps_queue.sv
sv/weighted_slot_priority_scheduler_core.sv
verif/wsps_sched_checker.sv
verif/weighted_slot_priority_scheduler_core_test.sv
